>>> sv/range_median_zone_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range median zone classifier
// Concurrent checks clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RANGE_MEDIAN_ZONE_CLASSIFIER_TOP_ASSERT_SVH
`define RANGE_MEDIAN_ZONE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define RMZC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMZC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rmzc_pkg.sv
// ----------------------------------------------------------------------------
// rmzc_pkg
// Shared types and constants of the range median zone classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rmzc_pkg;

  localparam int SENSOR_W     = 2;
  localparam int DIST_W       = 16;
  localparam int REG_W        = 16;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 5;
  localparam int REG_COUNT    = 5;

  localparam int SENSOR_COUNT_DEF = 3;
  localparam int WINDOW_LEN_DEF   = 5;
  localparam int DIST_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam int RING_FILL_MM = 4000;

  localparam logic [REG_W-1:0] MIN_RANGE_RST = 16'd20;
  localparam logic [REG_W-1:0] MAX_RANGE_RST = 16'd4000;
  localparam logic [REG_W-1:0] EMERG_RST     = 16'd300;
  localparam logic [REG_W-1:0] DANGER_RST    = 16'd800;
  localparam logic [REG_W-1:0] CAUTION_RST   = 16'd1500;

  typedef enum logic [2:0] {
    REG_MIN_RANGE = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_EMERGENCY = 3'd2,
    REG_DANGER    = 3'd3,
    REG_CAUTION   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ZONE_EMERGENCY = 2'd0,
    ZONE_DANGER    = 2'd1,
    ZONE_CAUTION   = 2'd2,
    ZONE_CLEAR     = 2'd3
  } zone_t;

  typedef struct packed {
    logic [REG_W-1:0] min_range_mm;
    logic [REG_W-1:0] max_range_mm;
    logic [REG_W-1:0] emergency_limit_mm;
    logic [REG_W-1:0] danger_limit_mm;
    logic [REG_W-1:0] caution_limit_mm;
  } cfg_regs_t;

endpackage

`default_nettype wire

>>> sv/rmzc_in_if.sv
// ----------------------------------------------------------------------------
// rmzc_in_if
// Reading channel: sensor id, raw distance and end-of-scan mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmzc_in_if;
  import rmzc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_id;
  logic [DIST_W-1:0]   distance_mm;
  logic                scan_end;

  modport source (output valid, output sensor_id, output distance_mm, output scan_end,
                  input ready);
  modport sink   (input valid, input sensor_id, input distance_mm, input scan_end,
                  output ready);
endinterface

`default_nettype wire

>>> sv/rmzc_out_if.sv
// ----------------------------------------------------------------------------
// rmzc_out_if
// Result channel: median, zone and end-of-scan stop report.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmzc_out_if;
  import rmzc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] out_sensor;
  logic [DIST_W-1:0]   median_mm;
  zone_t               zone;
  logic                stop_valid;
  logic [SENSOR_W-1:0] stop_sensor;
  logic [DIST_W-1:0]   stop_mm;

  modport source (output valid, output out_sensor, output median_mm, output zone,
                  output stop_valid, output stop_sensor, output stop_mm, input ready);
  modport sink   (input valid, input out_sensor, input median_mm, input zone,
                  input stop_valid, input stop_sensor, input stop_mm, output ready);
endinterface

`default_nettype wire

>>> sv/range_median_zone_classifier_top.sv
// ----------------------------------------------------------------------------
// range_median_zone_classifier_top
// A word is queued in the FIFO, then registered in median and result stages.
// Throughput: one word per cycle while results are not stalled; set by the
// combinational rank median and the scan record compare in the back part.
// Reset (rst, sync): rings fill to 4000 mm, pointers and scan record clear.
// ----------------------------------------------------------------------------
`default_nettype none

module range_median_zone_classifier_top #(
  parameter int SENSOR_COUNT = rmzc_pkg::SENSOR_COUNT_DEF,
  parameter int WINDOW_LEN   = rmzc_pkg::WINDOW_LEN_DEF,
  parameter int DIST_BITS    = rmzc_pkg::DIST_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  rmzc_in_if.sink                         reading,
  rmzc_out_if.source                      result,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [rmzc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire [rmzc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rmzc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rmzc_pkg::*;

  localparam int ENTRY_W = WINDOW_LEN * DIST_BITS + 4;

  cfg_regs_t          cfg;
  logic               push_valid;
  logic [ENTRY_W-1:0] push_data;
  logic               push_ready;
  logic               pop_valid;
  logic [ENTRY_W-1:0] pop_data;
  logic               pop_ready;

  rmzc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rmzc_front #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .WINDOW_LEN   (WINDOW_LEN),
    .DIST_BITS    (DIST_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rd         (reading),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rmzc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  rmzc_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .DIST_BITS  (DIST_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .res       (result)
  );

endmodule

`default_nettype wire

>>> sv/rmzc_cfg.sv
// ----------------------------------------------------------------------------
// rmzc_cfg
// APB register file holding the range and zone limits.
// ----------------------------------------------------------------------------
`default_nettype none

module rmzc_cfg (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [rmzc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire [rmzc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rmzc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output rmzc_pkg::cfg_regs_t             cfg
);
  import rmzc_pkg::*;

  reg_idx_t   idx;
  logic       wr_en;
  logic [REG_W-1:0] rd_val;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range_mm       <= MIN_RANGE_RST;
      cfg.max_range_mm       <= MAX_RANGE_RST;
      cfg.emergency_limit_mm <= EMERG_RST;
      cfg.danger_limit_mm    <= DANGER_RST;
      cfg.caution_limit_mm   <= CAUTION_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_RANGE: cfg.min_range_mm       <= pwdata[REG_W-1:0];
        REG_MAX_RANGE: cfg.max_range_mm       <= pwdata[REG_W-1:0];
        REG_EMERGENCY: cfg.emergency_limit_mm <= pwdata[REG_W-1:0];
        REG_DANGER:    cfg.danger_limit_mm    <= pwdata[REG_W-1:0];
        REG_CAUTION:   cfg.caution_limit_mm   <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_RANGE: rd_val = cfg.min_range_mm;
      REG_MAX_RANGE: rd_val = cfg.max_range_mm;
      REG_EMERGENCY: rd_val = cfg.emergency_limit_mm;
      REG_DANGER:    rd_val = cfg.danger_limit_mm;
      REG_CAUTION:   rd_val = cfg.caution_limit_mm;
      default:       rd_val = '0;
    endcase
    prdata = APB_DATA_W'(rd_val);
  end

endmodule

`default_nettype wire

>>> sv/rmzc_front.sv
// ----------------------------------------------------------------------------
// rmzc_front
// Accepts readings, maps out-of-range to max, updates ring and queues window.
// ----------------------------------------------------------------------------
`default_nettype none

module rmzc_front #(
  parameter int SENSOR_COUNT = rmzc_pkg::SENSOR_COUNT_DEF,
  parameter int WINDOW_LEN   = rmzc_pkg::WINDOW_LEN_DEF,
  parameter int DIST_BITS    = rmzc_pkg::DIST_BITS_DEF,
  parameter int ENTRY_W      = WINDOW_LEN * DIST_BITS + 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  rmzc_pkg::cfg_regs_t  cfg,
  rmzc_in_if.sink              rd,
  output logic                 push_valid,
  output logic [ENTRY_W-1:0]   push_data,
  input  wire                  push_ready
);
  import rmzc_pkg::*;

  localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int PTR_W  = $clog2(WINDOW_LEN);
  localparam int WIN_W  = WINDOW_LEN * DIST_BITS;
  localparam logic [DIST_BITS-1:0] FILL = DIST_BITS'(RING_FILL_MM);

  logic [DIST_BITS-1:0] ring [SENSOR_COUNT][WINDOW_LEN];
  logic [PTR_W-1:0]     ptr  [SENSOR_COUNT];

  logic [SIDX_W-1:0]    row;
  logic                 known;
  logic [DIST_BITS-1:0] raw;
  logic [DIST_BITS-1:0] min_mm;
  logic [DIST_BITS-1:0] max_mm;
  logic [DIST_BITS-1:0] clamped;
  logic [PTR_W-1:0]     cur_ptr;
  logic [PTR_W-1:0]     ptr_next;
  logic [DIST_BITS-1:0] win [WINDOW_LEN];

  assign row      = SIDX_W'(rd.sensor_id);
  assign known    = int'(rd.sensor_id) < SENSOR_COUNT;
  assign raw      = DIST_BITS'(rd.distance_mm);
  assign min_mm   = DIST_BITS'(cfg.min_range_mm);
  assign max_mm   = DIST_BITS'(cfg.max_range_mm);
  assign clamped  = (raw < min_mm || raw > max_mm) ? max_mm : raw;
  assign cur_ptr  = ptr[row];
  assign ptr_next = (cur_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : cur_ptr + PTR_W'(1);

  assign rd.ready   = push_ready;
  assign push_valid = rd.valid;

  always_comb begin
    for (int k = 0; k < WINDOW_LEN; k++) begin
      win[k] = (PTR_W'(k) == cur_ptr) ? clamped : ring[row][k];
      push_data[k*DIST_BITS +: DIST_BITS] = win[k];
    end
    push_data[WIN_W +: SENSOR_W] = rd.sensor_id;
    push_data[WIN_W + SENSOR_W]     = rd.scan_end;
    push_data[WIN_W + SENSOR_W + 1] = known;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        ptr[s] <= '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
          ring[s][k] <= FILL;
        end
      end
    end else if (rd.valid && push_ready && known) begin
      ring[row][cur_ptr] <= clamped;
      ptr[row]           <= ptr_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/rmzc_fifo.sv
// ----------------------------------------------------------------------------
// rmzc_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rmzc_fifo #(
  parameter int WIDTH = 84,
  parameter int DEPTH = rmzc_pkg::QUEUE_DEPTH
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push_valid,
  input  wire [WIDTH-1:0]   push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output logic [WIDTH-1:0]  pop_data,
  input  wire               pop_ready
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/rmzc_back.sv
// ----------------------------------------------------------------------------
// rmzc_back
// Median by rank selection, zone compare, scan emergency record, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module rmzc_back #(
  parameter int WINDOW_LEN = rmzc_pkg::WINDOW_LEN_DEF,
  parameter int DIST_BITS  = rmzc_pkg::DIST_BITS_DEF,
  parameter int ENTRY_W    = WINDOW_LEN * DIST_BITS + 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  rmzc_pkg::cfg_regs_t  cfg,
  input  wire                  pop_valid,
  input  wire [ENTRY_W-1:0]    pop_data,
  output logic                 pop_ready,
  rmzc_out_if.source           res
);
  import rmzc_pkg::*;

  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam int MID    = WINDOW_LEN / 2;
  localparam int WIN_W  = WINDOW_LEN * DIST_BITS;

  logic [DIST_BITS-1:0] w [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] lt;
  logic [RANK_W-1:0]    rank;
  logic [DIST_BITS-1:0] med_c;

  // median stage
  logic                 a_valid;
  logic [DIST_BITS-1:0] a_med;
  logic [SENSOR_W-1:0]  a_sid;
  logic                 a_end;
  logic                 a_known;
  logic                 a_ready;
  logic                 b_ready;

  // scan record
  logic                 has_emerg;
  logic [DIST_BITS-1:0] near_mm;
  logic [SENSOR_W-1:0]  near_sensor;

  logic                 emerg;
  zone_t                zone_c;
  logic                 has_next;
  logic [DIST_BITS-1:0] near_mm_next;
  logic [SENSOR_W-1:0]  near_sensor_next;

  always_comb begin
    med_c = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      w[i] = pop_data[i*DIST_BITS +: DIST_BITS];
    end
    for (int i = 0; i < WINDOW_LEN; i++) begin
      for (int j = 0; j < WINDOW_LEN; j++) begin
        lt[j] = (j != i) && ((w[j] < w[i]) || ((w[j] == w[i]) && (j < i)));
      end
      rank = RANK_W'($countones(lt));
      if (rank == RANK_W'(MID)) begin
        med_c = w[i];
      end
    end
  end

  assign b_ready   = !res.valid || res.ready;
  assign a_ready   = !a_valid || b_ready;
  assign pop_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && pop_valid) begin
      a_known <= pop_data[WIN_W + SENSOR_W + 1];
      a_end   <= pop_data[WIN_W + SENSOR_W];
      a_sid   <= pop_data[WIN_W +: SENSOR_W];
      a_med   <= pop_data[WIN_W + SENSOR_W + 1] ? med_c : '0;
    end
  end

  always_comb begin
    emerg = a_known && (a_med < DIST_BITS'(cfg.emergency_limit_mm));
    if (!a_known) begin
      zone_c = ZONE_CLEAR;
    end else if (emerg) begin
      zone_c = ZONE_EMERGENCY;
    end else if (a_med < DIST_BITS'(cfg.danger_limit_mm)) begin
      zone_c = ZONE_DANGER;
    end else if (a_med < DIST_BITS'(cfg.caution_limit_mm)) begin
      zone_c = ZONE_CAUTION;
    end else begin
      zone_c = ZONE_CLEAR;
    end
    has_next         = has_emerg || emerg;
    near_mm_next     = near_mm;
    near_sensor_next = near_sensor;
    if (emerg && (!has_emerg || a_med < near_mm)) begin
      near_mm_next     = a_med;
      near_sensor_next = a_sid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid   <= 1'b0;
      has_emerg   <= 1'b0;
      near_mm     <= '1;
      near_sensor <= '0;
    end else if (b_ready) begin
      res.valid <= a_valid;
      if (a_valid) begin
        if (a_end) begin
          has_emerg   <= 1'b0;
          near_mm     <= '1;
          near_sensor <= '0;
        end else begin
          has_emerg   <= has_next;
          near_mm     <= near_mm_next;
          near_sensor <= near_sensor_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      res.out_sensor  <= a_sid;
      res.median_mm   <= DIST_W'(a_med);
      res.zone        <= zone_c;
      res.stop_valid  <= a_end && has_next;
      res.stop_sensor <= (a_end && has_next) ? near_sensor_next : '0;
      res.stop_mm     <= (a_end && has_next) ? DIST_W'(near_mm_next) : '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/rmzc_checker.sv
// ----------------------------------------------------------------------------
// rmzc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_median_zone_classifier_top_assert.svh"

module rmzc_checker #(
  parameter int SENSOR_COUNT = rmzc_pkg::SENSOR_COUNT_DEF
) (
  input wire                           clk,
  input wire                           rst,
  input wire                           valid,
  input wire                           ready,
  input wire [rmzc_pkg::SENSOR_W-1:0]  out_sensor,
  input wire [rmzc_pkg::DIST_W-1:0]    median_mm,
  input rmzc_pkg::zone_t               zone,
  input wire                           stop_valid,
  input wire [rmzc_pkg::SENSOR_W-1:0]  stop_sensor,
  input wire [rmzc_pkg::DIST_W-1:0]    stop_mm
);
  import rmzc_pkg::*;

  `RMZC_ASSERT_IMPLY(a_stop_fields_zero, valid && !stop_valid,
    stop_sensor == '0 && stop_mm == '0, "stop fields set without stop")
  `RMZC_ASSERT_IMPLY(a_unknown_sensor, valid && int'(out_sensor) >= SENSOR_COUNT,
    median_mm == '0 && zone == ZONE_CLEAR, "unknown sensor not reported clear")
  `RMZC_ASSERT_IMPLY(a_emerg_known, valid && zone == ZONE_EMERGENCY,
    int'(out_sensor) < SENSOR_COUNT, "emergency on unknown sensor")
  `RMZC_ASSERT_NEXT(a_stall_hold, valid && !ready,
    valid && $stable({out_sensor, median_mm, zone, stop_valid, stop_sensor, stop_mm}),
    "result changed while stalled")

endmodule

bind range_median_zone_classifier_top rmzc_checker #(
  .SENSOR_COUNT (SENSOR_COUNT)
) u_rmzc_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .out_sensor  (result.out_sensor),
  .median_mm   (result.median_mm),
  .zone        (result.zone),
  .stop_valid  (result.stop_valid),
  .stop_sensor (result.stop_sensor),
  .stop_mm     (result.stop_mm)
);

`default_nettype wire
